FILE: hdl/dpvl_pkg.sv
`default_nettype none
package dpvl_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_STEPS = 32;
	localparam int ADDR_W = 5;

	typedef logic signed [31:0] q_t;

	// register map, word index
	typedef enum logic [2:0] {
		REG_UPPER  = 3'd0,
		REG_LOWER  = 3'd1,
		REG_VLIM   = 3'd2,
		REG_MARGIN = 3'd3,
		REG_TSTEP  = 3'd4
	} reg_idx_t;

	// which limiting rule applies to an item
	typedef enum logic [2:0] {
		RULE_NONE,
		RULE_CUR_UP,
		RULE_CUR_LO,
		RULE_POS_UP,
		RULE_DAMP_UP,
		RULE_POS_LO,
		RULE_DAMP_LO
	} rule_t;

	typedef struct packed {
		q_t    cur;
		q_t    pos;
		q_t    vel;
		rule_t rule;
	} meta_t;

	localparam logic signed [63:0] S64_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'shFFFF_FFFF_8000_0000;
	localparam logic [30:0] MARGIN_RESET = 31'((1 << FRAC_BITS) / 100);

	// saturate a wide signed value to 32 bits
	function automatic q_t sat32(input logic signed [63:0] x);
		q_t r;
		if (x > S64_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < S64_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/dpvl_in_if.sv
`default_nettype none
interface dpvl_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] current_position;
	logic [31:0] proposed_position;
	logic [31:0] proposed_velocity;

	modport source (output valid, current_position, proposed_position, proposed_velocity,
		input ready);
	modport sink (input valid, current_position, proposed_position, proposed_velocity,
		output ready);
endinterface
`default_nettype wire

FILE: hdl/dpvl_out_if.sv
`default_nettype none
interface dpvl_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] limited_position;
	logic [31:0] limited_velocity;

	modport source (output valid, limited_position, limited_velocity, input ready);
	modport sink (input valid, limited_position, limited_velocity, output ready);
endinterface
`default_nettype wire

FILE: hdl/damped_position_velocity_limiter.sv
// Throughput: one request per cycle unless the output is stalled; each stage holds
// independently, so bubbles are absorbed while a result waits at the output register.
// The 32 bit-per-stage divider stages set the latency.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
`default_nettype none
module damped_position_velocity_limiter (
	input  wire                           clk,
	input  wire                           arst_n,
	dpvl_in_if.sink                       sample,
	dpvl_out_if.source                    result,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [dpvl_pkg::ADDR_W-1:0]    paddr,
	input  wire [31:0]                    pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int NDIV = dpvl_pkg::DIV_STEPS;
	localparam int NST  = NDIV + 9;
	localparam int ST6  = 5;
	localparam int ST8  = ST6 + NDIV + 1;
	localparam int ST9  = ST8 + 1;
	localparam int ST10 = ST9 + 1;

	// configuration registers
	dpvl_pkg::q_t upper_q, lower_q;
	logic [30:0]  vlim_q, margin_q, tstep_q;
	logic [2:0]   widx;

	assign widx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= 32'sh7FFF_FFFF;
			lower_q  <= 32'sh8000_0000;
			vlim_q   <= 31'h7FFF_FFFF;
			margin_q <= dpvl_pkg::MARGIN_RESET;
			tstep_q  <= dpvl_pkg::MARGIN_RESET;
		end else if (psel && penable && pwrite) begin
			case (widx)
				dpvl_pkg::REG_UPPER:  upper_q  <= pwdata;
				dpvl_pkg::REG_LOWER:  lower_q  <= pwdata;
				dpvl_pkg::REG_VLIM:   vlim_q   <= pwdata[30:0];
				dpvl_pkg::REG_MARGIN: margin_q <= pwdata[30:0];
				dpvl_pkg::REG_TSTEP:  tstep_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (widx)
			dpvl_pkg::REG_UPPER:  prdata = upper_q;
			dpvl_pkg::REG_LOWER:  prdata = lower_q;
			dpvl_pkg::REG_VLIM:   prdata = {1'b0, vlim_q};
			dpvl_pkg::REG_MARGIN: prdata = {1'b0, margin_q};
			dpvl_pkg::REG_TSTEP:  prdata = {1'b0, tstep_q};
			default:              prdata = '0;
		endcase
	end

	// per-stage valid bits and hold chain
	logic [NST-1:0] vld_s;
	logic [NST-1:0] en;
	logic [NST-1:0] vin;

	always_comb begin
		en[NST-1] = !vld_s[NST-1] || result.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
		vin[0] = sample.valid;
		for (int k = 1; k < NST; k++) begin
			vin[k] = vld_s[k-1];
		end
	end

	assign sample.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vin[k];
				end
			end
		end
	end

	// stage 1: out-of-bounds check and velocity clamp
	dpvl_pkg::q_t       cur_in, pos_in, vel_in;
	logic signed [32:0] vel_x, vl_x;
	dpvl_pkg::q_t       velc_c;
	logic               clamp_c;
	dpvl_pkg::rule_t    pre_c;

	assign cur_in = sample.current_position;
	assign pos_in = sample.proposed_position;
	assign vel_in = sample.proposed_velocity;

	always_comb begin
		vel_x = 33'(vel_in);
		vl_x  = $signed({2'b00, vlim_q});
		velc_c  = vel_in;
		clamp_c = 1'b0;
		if (cur_in > upper_q) begin
			pre_c = dpvl_pkg::RULE_CUR_UP;
		end else if (cur_in < lower_q) begin
			pre_c = dpvl_pkg::RULE_CUR_LO;
		end else begin
			pre_c = dpvl_pkg::RULE_NONE;
		end
		if (vel_x > vl_x) begin
			velc_c  = {1'b0, vlim_q};
			clamp_c = 1'b1;
		end else if (vel_x < -vl_x) begin
			velc_c  = 32'(-vl_x);
			clamp_c = 1'b1;
		end
	end

	dpvl_pkg::meta_t meta_s1;
	logic            clamp_s1;

	always_ff @(posedge clk) begin
		if (en[0] && vin[0]) begin
			meta_s1  <= '{cur: cur_in, pos: pos_in, vel: velc_c, rule: pre_c};
			clamp_s1 <= clamp_c && (pre_c == dpvl_pkg::RULE_NONE);
		end
	end

	// stage 2: clamped velocity times time step
	dpvl_pkg::meta_t    meta_s2;
	logic               clamp_s2;
	logic signed [63:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en[1] && vin[1]) begin
			meta_s2  <= meta_s1;
			clamp_s2 <= clamp_s1;
			prod_s2  <= meta_s1.vel * $signed({1'b0, tstep_q});
		end
	end

	// stage 3: recomputed position after clamp
	dpvl_pkg::meta_t    meta_s3;
	logic signed [63:0] adv2_c;

	assign adv2_c = 64'(meta_s2.cur) + (prod_s2 >>> dpvl_pkg::FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en[2] && vin[2]) begin
			meta_s3 <= '{cur: meta_s2.cur,
				pos: clamp_s2 ? dpvl_pkg::sat32(adv2_c) : meta_s2.pos,
				vel: meta_s2.vel, rule: meta_s2.rule};
		end
	end

	// stage 4: rule selection and difference for the divider
	logic signed [33:0] up34, lo34, cur34, pos34, mw34;
	dpvl_pkg::rule_t    rule_c;
	logic signed [33:0] diff_c;

	always_comb begin
		up34  = 34'(upper_q);
		lo34  = 34'(lower_q);
		cur34 = 34'(meta_s3.cur);
		pos34 = 34'(meta_s3.pos);
		mw34  = $signed({3'b000, margin_q});
		rule_c = meta_s3.rule;
		if (meta_s3.rule == dpvl_pkg::RULE_NONE) begin
			if (pos34 > up34) begin
				rule_c = dpvl_pkg::RULE_POS_UP;
			end else if (pos34 > up34 - mw34 && meta_s3.vel > 0) begin
				rule_c = dpvl_pkg::RULE_DAMP_UP;
			end else if (pos34 < lo34) begin
				rule_c = dpvl_pkg::RULE_POS_LO;
			end else if (pos34 < lo34 + mw34 && meta_s3.vel < 0) begin
				rule_c = dpvl_pkg::RULE_DAMP_LO;
			end
		end
		case (rule_c)
			dpvl_pkg::RULE_CUR_UP, dpvl_pkg::RULE_POS_UP: diff_c = up34 - cur34;
			dpvl_pkg::RULE_CUR_LO, dpvl_pkg::RULE_POS_LO: diff_c = lo34 - cur34;
			dpvl_pkg::RULE_DAMP_UP:                       diff_c = up34 - pos34;
			dpvl_pkg::RULE_DAMP_LO:                       diff_c = pos34 - lo34;
			default:                                      diff_c = '0;
		endcase
	end

	dpvl_pkg::meta_t    meta_s4;
	logic signed [33:0] diff_s4;

	always_ff @(posedge clk) begin
		if (en[3] && vin[3]) begin
			meta_s4 <= '{cur: meta_s3.cur, pos: meta_s3.pos, vel: meta_s3.vel,
				rule: rule_c};
			diff_s4 <= diff_c;
		end
	end

	// stage 5: dividend and divisor magnitudes
	logic        damp_c;
	logic [33:0] dabs_c;
	logic [32:0] vabs_c;
	logic [63:0] dprod_c;

	always_comb begin
		damp_c = (meta_s4.rule == dpvl_pkg::RULE_DAMP_UP) ||
			(meta_s4.rule == dpvl_pkg::RULE_DAMP_LO);
		dabs_c = (diff_s4 < 0) ? 34'(-diff_s4) : 34'(diff_s4);
		vabs_c = (meta_s4.vel < 0) ? 33'(-33'(meta_s4.vel)) : 33'(meta_s4.vel);
		dprod_c = vabs_c[31:0] * dabs_c[31:0];
	end

	dpvl_pkg::meta_t meta_s5;
	logic [63:0]     num_s5;
	logic [30:0]     den_s5;
	logic            neg_s5;

	always_ff @(posedge clk) begin
		if (en[4] && vin[4]) begin
			meta_s5 <= meta_s4;
			if (damp_c) begin
				num_s5 <= dprod_c;
				den_s5 <= margin_q;
				neg_s5 <= meta_s4.vel < 0;
			end else begin
				num_s5 <= 64'(dabs_c) << dpvl_pkg::FRAC_BITS;
				den_s5 <= tstep_q;
				neg_s5 <= diff_s4 < 0;
			end
		end
	end

	// stage 6: quotient overflow and zero detection
	dpvl_pkg::meta_t meta_d  [NDIV+1];
	logic [63:0]     rem_d   [NDIV+1];
	logic [31:0]     quo_d   [NDIV+1];
	logic [30:0]     den_d   [NDIV+1];
	logic            neg_d   [NDIV+1];
	logic            ovf_d   [NDIV+1];
	logic            zero_d  [NDIV+1];

	always_ff @(posedge clk) begin
		if (en[ST6] && vin[ST6]) begin
			meta_d[0] <= meta_s5;
			rem_d[0]  <= num_s5;
			quo_d[0]  <= '0;
			den_d[0]  <= den_s5;
			neg_d[0]  <= neg_s5;
			ovf_d[0]  <= num_s5 >= {1'b0, den_s5, 32'b0};
			zero_d[0] <= num_s5 == '0;
		end
	end

	// restoring divider, one quotient bit per stage, msb first
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		localparam int BIT = NDIV - 1 - k;
		logic [63:0] trial;
		logic        take;

		assign trial = 64'(den_d[k]) << BIT;
		assign take  = rem_d[k] >= trial;

		always_ff @(posedge clk) begin
			if (en[ST6+1+k] && vin[ST6+1+k]) begin
				meta_d[k+1] <= meta_d[k];
				rem_d[k+1]  <= take ? rem_d[k] - trial : rem_d[k];
				quo_d[k+1]  <= quo_d[k] | (32'(take) << BIT);
				den_d[k+1]  <= den_d[k];
				neg_d[k+1]  <= neg_d[k];
				ovf_d[k+1]  <= ovf_d[k];
				zero_d[k+1] <= zero_d[k];
			end
		end
	end

	// stage 8: signed saturated quotient and final velocity
	logic signed [34:0] qm_c, qs_c;
	dpvl_pkg::q_t       qv_c, vneg_c, velf_c;
	dpvl_pkg::meta_t    mq;

	always_comb begin
		mq = meta_d[NDIV];
		if (zero_d[NDIV]) begin
			qm_c = '0;
		end else if (ovf_d[NDIV]) begin
			qm_c = 35'sd4294967296;
		end else begin
			qm_c = $signed({3'b000, quo_d[NDIV]});
		end
		qs_c   = neg_d[NDIV] ? -qm_c : qm_c;
		qv_c   = dpvl_pkg::sat32(64'(qs_c));
		vneg_c = 32'(-$signed({1'b0, vlim_q}));
		case (mq.rule)
			dpvl_pkg::RULE_CUR_UP: velf_c = (qv_c < vneg_c) ? vneg_c : qv_c;
			dpvl_pkg::RULE_CUR_LO: velf_c = (qv_c > $signed({1'b0, vlim_q})) ?
				$signed({1'b0, vlim_q}) : qv_c;
			dpvl_pkg::RULE_NONE:   velf_c = mq.vel;
			default:               velf_c = qv_c;
		endcase
	end

	dpvl_pkg::meta_t meta_s8;

	always_ff @(posedge clk) begin
		if (en[ST8] && vin[ST8]) begin
			meta_s8 <= '{cur: mq.cur, pos: mq.pos, vel: velf_c, rule: mq.rule};
		end
	end

	// stage 9: final velocity times time step
	dpvl_pkg::meta_t    meta_s9;
	logic signed [63:0] prod_s9;

	always_ff @(posedge clk) begin
		if (en[ST9] && vin[ST9]) begin
			meta_s9 <= meta_s8;
			prod_s9 <= meta_s8.vel * $signed({1'b0, tstep_q});
		end
	end

	// stage 10: output register, position advanced by the final velocity when a rule applies
	logic signed [63:0] adv9_c;
	dpvl_pkg::q_t       pos_s10, vel_s10;

	assign adv9_c = 64'(meta_s9.cur) + (prod_s9 >>> dpvl_pkg::FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en[ST10] && vin[ST10]) begin
			vel_s10 <= meta_s9.vel;
			pos_s10 <= (meta_s9.rule == dpvl_pkg::RULE_NONE) ? meta_s9.pos :
				dpvl_pkg::sat32(adv9_c);
		end
	end

	assign result.valid            = vld_s[NST-1];
	assign result.limited_position = pos_s10;
	assign result.limited_velocity = vel_s10;

endmodule
`default_nettype wire
